// File: src/srld_pkg.sv
package srld_pkg;

   localparam int RING_SLOTS  = 64;
   localparam int SLOT_W      = $clog2(RING_SLOTS);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] OP_RX    = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_EMPTY = 2'd1;
   localparam logic [1:0] KIND_TX    = 2'd2;

   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_SEMI = 8'h3B;

   localparam logic [2:0] CSR_BLOCKING  = 3'd0;
   localparam logic [2:0] CSR_ECHO      = 3'd1;
   localparam logic [2:0] CSR_CRLF      = 3'd2;
   localparam logic [2:0] CSR_LINE_MODE = 3'd3;
   localparam logic [2:0] CSR_SEMI_EOL  = 3'd4;

   typedef enum logic [1:0] {
      CMD_DELIVER,
      CMD_EMPTY,
      CMD_TX
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   ch;
   } cmd_type;

   typedef struct packed {
      logic blocking;
      logic echo;
      logic crlf;
      logic line_mode;
      logic semi_eol;
   } cfg_type;

   // Both ring pointers walk downwards and wrap from slot 1 to the top slot.
   function automatic logic [SLOT_W-1:0] step_down(input logic [SLOT_W-1:0] slot);
      logic [SLOT_W-1:0] result;
      if ((slot <= SLOT_W'(1)) || (slot > SLOT_W'(RING_SLOTS - 1))) begin
         result = SLOT_W'(RING_SLOTS - 1);
      end else begin
         result = slot - SLOT_W'(1);
      end
      return result;
   endfunction

endpackage

// File: src/srld_req_if.sv
interface srld_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] data_in;

   modport source (output valid, output op, output data_in, input ready);
   modport sink (input valid, input op, input data_in, output ready);
endinterface

// File: src/srld_rsp_if.sv
interface srld_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_out;
   logic       last;

   modport source (output valid, output kind, output data_out, output last, input ready);
   modport sink (input valid, input kind, input data_out, input last, output ready);
endinterface

// File: src/serial_rx_ring_line_discipline.sv
// Serial receive ring with a terminal line discipline.
// Requests arrive on req_chan (valid/ready): op selects a byte received from the
// line, a host read, or a host character to transmit; data_in carries the byte.
// Responses leave on rsp_chan (valid/ready) as kind, data_out and last, where last
// marks the final response of a request. A request yields zero to three responses.
// Settings are written through csr_we, csr_index and csr_wdata; the user must
// write them only while the block is idle, as the block itself does not enforce it.
// A classifying front end owns the ring pointers and the 64-slot ring memory and
// feeds a four-entry command queue; a back end expands each command into responses.
// A read that finds data passes through the fetch state for the registered ring
// read, and no request is accepted meanwhile. A command moves from the queue into
// the back end's pending flags and then to the output register; the back end issues
// one response per cycle while rsp_chan.ready holds, popping a command only when idle.
// Reset empties the ring, drops any held read and restores the default settings;
// the ring memory itself needs no clearing.
// While the receiver stalls, the output register holds its response, the queue
// fills, and req_chan.ready falls once the queue is full.
module serial_rx_ring_line_discipline (
   input  logic       clock,
   input  logic       reset,
   srld_req_if.sink   req_chan,
   srld_rsp_if.source rsp_chan,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [0:0] csr_wdata
);
   import srld_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    push_valid;
   cmd_type push_cmd;
   logic    push_ready;
   logic    pop_valid;
   cmd_type pop_cmd;
   logic    pop_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BLOCKING:  cfg_in.blocking  = csr_wdata[0];
            CSR_ECHO:      cfg_in.echo      = csr_wdata[0];
            CSR_CRLF:      cfg_in.crlf      = csr_wdata[0];
            CSR_LINE_MODE: cfg_in.line_mode = csr_wdata[0];
            CSR_SEMI_EOL:  cfg_in.semi_eol  = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{blocking: 1'b1, echo: 1'b1, crlf: 1'b0, line_mode: 1'b0,
                     semi_eol: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   srld_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   srld_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   srld_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

// File: src/srld_front.sv
module srld_front (
   input  logic             clock,
   input  logic             reset,
   srld_req_if.sink         req_chan,
   input  srld_pkg::cfg_type cfg,
   output logic             push_valid,
   output srld_pkg::cmd_type push_cmd,
   input  logic             push_ready
);
   import srld_pkg::*;

   typedef enum logic {
      F_IDLE,
      F_FETCH
   } front_state_type;

   front_state_type   state_ff, state_in;
   logic [SLOT_W-1:0] write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0] read_slot_ff, read_slot_in;
   logic              waiting_ff, waiting_in;
   logic [7:0]        mem_q_ff;
   logic [7:0]        ring_mem [RING_SLOTS];

   logic              accept;
   logic [SLOT_W-1:0] next_wr;
   logic [SLOT_W-1:0] next_rd;
   logic              mem_we;
   logic              mem_re;

   assign req_chan.ready = (state_ff == F_IDLE) && push_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign next_wr        = step_down(write_slot_ff);
   assign next_rd        = step_down(read_slot_ff);

   always_comb begin
      state_in      = state_ff;
      write_slot_in = write_slot_ff;
      read_slot_in  = read_slot_ff;
      waiting_in    = waiting_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      push_valid    = 1'b0;
      push_cmd      = '{kind: CMD_TX, ch: req_chan.data_in};
      if (state_ff == F_FETCH) begin
         push_valid = 1'b1;
         push_cmd   = '{kind: CMD_DELIVER, ch: mem_q_ff};
         state_in   = F_IDLE;
      end else if (accept) begin
         unique case (req_chan.op)
            OP_RX: begin
               if (next_wr != read_slot_ff) begin
                  write_slot_in = next_wr;
                  mem_we        = 1'b1;
                  // A held read takes the byte just stored, so it bypasses the ring.
                  if (waiting_ff) begin
                     waiting_in   = 1'b0;
                     read_slot_in = next_rd;
                     push_valid   = 1'b1;
                     push_cmd     = '{kind: CMD_DELIVER, ch: req_chan.data_in};
                  end
               end
            end
            OP_READ: begin
               if (write_slot_ff != read_slot_ff) begin
                  read_slot_in = next_rd;
                  mem_re       = 1'b1;
                  state_in     = F_FETCH;
               end else if (waiting_ff || cfg.blocking) begin
                  waiting_in = 1'b1;
               end else begin
                  push_valid = 1'b1;
                  push_cmd   = '{kind: CMD_EMPTY, ch: 8'h00};
               end
            end
            OP_WRITE: begin
               push_valid = 1'b1;
               push_cmd   = '{kind: CMD_TX, ch: req_chan.data_in};
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= F_IDLE;
         write_slot_ff <= SLOT_W'(1);
         read_slot_ff  <= SLOT_W'(1);
         waiting_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         write_slot_ff <= write_slot_in;
         read_slot_ff  <= read_slot_in;
         waiting_ff    <= waiting_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[next_wr] <= req_chan.data_in;
      end
      if (mem_re) begin
         mem_q_ff <= ring_mem[next_rd];
      end
   end

`ifndef ASSERT_OFF
   a_wait_on_empty: assert property (@(posedge clock) disable iff (reset)
      waiting_ff |-> (write_slot_ff == read_slot_ff))
      else $error("read held while the ring holds data");

   a_fetch_has_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == F_FETCH) |-> push_ready)
      else $error("fetched byte has no room in the command queue");
`endif

endmodule

// File: src/srld_cmd_queue.sv
module srld_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  srld_pkg::cmd_type push_cmd,
   output logic              push_ready,
   output logic              pop_valid,
   output srld_pkg::cmd_type pop_cmd,
   input  logic              pop_ready
);
   import srld_pkg::*;

   cmd_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef ASSERT_OFF
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("command queue pointers disagree with its count");
`endif

endmodule

// File: src/srld_back.sv
module srld_back (
   input  logic              clock,
   input  logic              reset,
   input  srld_pkg::cfg_type cfg,
   input  logic              pop_valid,
   input  srld_pkg::cmd_type pop_cmd,
   output logic              pop_ready,
   srld_rsp_if.source        rsp_chan
);
   import srld_pkg::*;

   logic       pend_read_ff, pend_read_in;
   logic       pend_empty_ff, pend_empty_in;
   logic       pend_tx_ff, pend_tx_in;
   logic       pend_cr_ff, pend_cr_in;
   logic [7:0] ch_ff, ch_in;
   logic       out_valid_ff, out_valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;

   logic       busy;
   logic       out_free;
   logic [7:0] xlat_ch;

   assign busy      = pend_read_ff || pend_empty_ff || pend_tx_ff || pend_cr_ff;
   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign pop_ready = !busy;

   // Line mode turns carriage returns, and semicolons when enabled, into line feeds.
   always_comb begin
      xlat_ch = pop_cmd.ch;
      if (cfg.line_mode && ((pop_cmd.ch == CH_CR) ||
                            (cfg.semi_eol && (pop_cmd.ch == CH_SEMI)))) begin
         xlat_ch = CH_LF;
      end
   end

   always_comb begin
      pend_read_in  = pend_read_ff;
      pend_empty_in = pend_empty_ff;
      pend_tx_in    = pend_tx_ff;
      pend_cr_in    = pend_cr_ff;
      ch_in         = ch_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      kind_in       = kind_ff;
      data_in       = data_ff;
      last_in       = last_ff;
      if (!busy) begin
         if (pop_valid) begin
            unique case (pop_cmd.kind)
               CMD_DELIVER: begin
                  pend_read_in = 1'b1;
                  pend_tx_in   = cfg.echo;
                  pend_cr_in   = cfg.echo && cfg.crlf && (xlat_ch == CH_LF);
                  ch_in        = xlat_ch;
               end
               CMD_EMPTY: begin
                  pend_empty_in = 1'b1;
                  ch_in         = 8'h00;
               end
               CMD_TX: begin
                  pend_tx_in = 1'b1;
                  pend_cr_in = cfg.crlf && (pop_cmd.ch == CH_LF);
                  ch_in      = pop_cmd.ch;
               end
               default: begin
               end
            endcase
         end
      end else if (out_free) begin
         out_valid_in = 1'b1;
         if (pend_read_ff) begin
            pend_read_in = 1'b0;
            kind_in      = KIND_READ;
            data_in      = ch_ff;
            last_in      = !(pend_tx_ff || pend_cr_ff);
         end else if (pend_empty_ff) begin
            pend_empty_in = 1'b0;
            kind_in       = KIND_EMPTY;
            data_in       = 8'h00;
            last_in       = 1'b1;
         end else if (pend_tx_ff) begin
            pend_tx_in = 1'b0;
            kind_in    = KIND_TX;
            data_in    = ch_ff;
            last_in    = !pend_cr_ff;
         end else begin
            pend_cr_in = 1'b0;
            kind_in    = KIND_TX;
            data_in    = CH_CR;
            last_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_read_ff  <= 1'b0;
         pend_empty_ff <= 1'b0;
         pend_tx_ff    <= 1'b0;
         pend_cr_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_read_ff  <= pend_read_in;
         pend_empty_ff <= pend_empty_in;
         pend_tx_ff    <= pend_tx_in;
         pend_cr_ff    <= pend_cr_in;
         out_valid_ff  <= out_valid_in;
      end
      ch_ff   <= ch_in;
      kind_ff <= kind_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.kind     = kind_ff;
   assign rsp_chan.data_out = data_ff;
   assign rsp_chan.last     = last_ff;

`ifndef ASSERT_OFF
   a_cr_after_lf: assert property (@(posedge clock) disable iff (reset)
      pend_cr_ff |-> (ch_ff == CH_LF))
      else $error("carriage return queued after a character other than line feed");

   a_empty_alone: assert property (@(posedge clock) disable iff (reset)
      pend_empty_ff |-> !(pend_read_ff || pend_tx_ff || pend_cr_ff))
      else $error("empty response mixed with other responses");
`endif

endmodule

// File: sim/serial_rx_ring_line_discipline_tb.sv
module serial_rx_ring_line_discipline_tb;
   import srld_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int SETTLE_TICKS = 20;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [2:0] CSR_SPARE_LO  = 3'd5;
   localparam logic [2:0] CSR_SPARE_MID = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI  = 3'd7;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data;
   } serial_req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] ch;
      logic       last;
   } line_result_type;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [2:0] csr_index;
   logic [0:0] csr_wdata;

   srld_req_if req_ch ();
   srld_rsp_if rsp_ch ();

   serial_rx_ring_line_discipline dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_ch),
      .rsp_chan  (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   serial_req_type  pending_reqs[$];
   line_result_type awaited_results[$];

   // Own copy of the ring, its pointers and the settings.
   logic [7:0]        ring_copy [RING_SLOTS];
   logic [SLOT_W-1:0] wr_slot;
   logic [SLOT_W-1:0] rd_slot;
   logic              read_held;
   cfg_type           model_cfg;

   int mismatch_count = 0;
   int cycle_count    = 0;
   int req_gap        = 0;
   int rsp_stall      = 0;
   bit req_calm       = 1'b0;
   bit rsp_calm       = 1'b0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Pointers walk downwards; below slot 1 they wrap to the top slot.
   function automatic logic [SLOT_W-1:0] slot_below(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] n;
      if (s > SLOT_W'(1) && s <= SLOT_W'(RING_SLOTS - 1)) begin
         n = s - SLOT_W'(1);
      end else begin
         n = SLOT_W'(RING_SLOTS - 1);
      end
      return n;
   endfunction

   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] pick_char();
      logic [7:0] c;
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 4))
            0: c = CH_CR;
            1: c = CH_LF;
            2: c = CH_SEMI;
            3: c = 8'h00;
            default: c = 8'hFF;
         endcase
      end else begin
         c = 8'($urandom_range(0, 255));
      end
      return c;
   endfunction

   function automatic serial_req_type pick_req();
      serial_req_type rq;
      int r;
      r = $urandom_range(0, 99);
      if (r < 42) begin
         rq.op = OP_RX;
      end else if (r < 76) begin
         rq.op = OP_READ;
      end else if (r < 95) begin
         rq.op = OP_WRITE;
      end else begin
         rq.op = OP_UNUSED;
      end
      rq.data = pick_char();
      return rq;
   endfunction

   task automatic emit_result(input logic [1:0] kind, input logic [7:0] ch);
      line_result_type r;
      r.kind = kind;
      r.ch   = ch;
      r.last = 1'b0;
      awaited_results.push_back(r);
   endtask

   task automatic send_to_tx(input logic [7:0] ch);
      emit_result(KIND_TX, ch);
      if (model_cfg.crlf && ch == CH_LF) begin
         emit_result(KIND_TX, CH_CR);
      end
   endtask

   task automatic take_oldest();
      logic [7:0] ch;
      rd_slot = slot_below(rd_slot);
      ch = ring_copy[rd_slot];
      if (model_cfg.line_mode &&
          (ch == CH_CR || (model_cfg.semi_eol && ch == CH_SEMI))) begin
         ch = CH_LF;
      end
      emit_result(KIND_READ, ch);
      if (model_cfg.echo) begin
         send_to_tx(ch);
      end
   endtask

   task automatic apply_request(input serial_req_type rq);
      int                before_count;
      logic [SLOT_W-1:0] nxt;
      before_count = awaited_results.size();
      case (rq.op)
         OP_RX: begin
            nxt = slot_below(wr_slot);
            // A full ring drops the byte and leaves the pointers alone.
            if (nxt != rd_slot) begin
               wr_slot = nxt;
               ring_copy[nxt] = rq.data;
               if (read_held) begin
                  read_held = 1'b0;
                  take_oldest();
               end
            end
         end
         OP_READ: begin
            if (wr_slot != rd_slot) begin
               take_oldest();
            end else if (read_held || model_cfg.blocking) begin
               read_held = 1'b1;
            end else begin
               emit_result(KIND_EMPTY, 8'h00);
            end
         end
         OP_WRITE: begin
            send_to_tx(rq.data);
         end
         default: begin
         end
      endcase
      if (awaited_results.size() > before_count) begin
         awaited_results[awaited_results.size() - 1].last = 1'b1;
      end
   endtask

   task automatic queue_req(input logic [1:0] op, input logic [7:0] d);
      serial_req_type rq;
      rq.op   = op;
      rq.data = d;
      pending_reqs.push_back(rq);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic bit_val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= bit_val;
      case (idx)
         CSR_BLOCKING:  model_cfg.blocking  = bit_val;
         CSR_ECHO:      model_cfg.echo      = bit_val;
         CSR_CRLF:      model_cfg.crlf      = bit_val;
         CSR_LINE_MODE: model_cfg.line_mode = bit_val;
         CSR_SEMI_EOL:  model_cfg.semi_eol  = bit_val;
         default: begin
         end
      endcase
   endtask

   task automatic finish_writes();
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_cfg(input cfg_type c);
      write_reg(CSR_BLOCKING, c.blocking);
      write_reg(CSR_ECHO, c.echo);
      write_reg(CSR_CRLF, c.crlf);
      write_reg(CSR_LINE_MODE, c.line_mode);
      write_reg(CSR_SEMI_EOL, c.semi_eol);
      finish_writes();
   endtask

   // Waits until every request has gone in and every response has come back,
   // then gives a held-over byte or dropped request time to clear the pipeline.
   task automatic settle();
      while (pending_reqs.size() != 0 || req_ch.valid || awaited_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   always @(posedge clock) begin : drive_requests
      serial_req_type seen_req;
      serial_req_type nxt_req;
      logic           free;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         free = !req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            seen_req.op   = req_ch.op;
            seen_req.data = req_ch.data_in;
            apply_request(seen_req);
            free = 1'b1;
         end
         if (free) begin
            if (req_gap > 0) begin
               req_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               nxt_req = pending_reqs.pop_front();
               req_ch.valid   <= 1'b1;
               req_ch.op      <= nxt_req.op;
               req_ch.data_in <= nxt_req.data;
               req_gap = pick_gap(req_calm);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_responses
      line_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response kind %0d data %02h last %0d", $time,
                        rsp_ch.kind, rsp_ch.data_out, rsp_ch.last);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_ch.kind !== want.kind || rsp_ch.data_out !== want.ch ||
                   rsp_ch.last !== want.last) begin
                  mismatch_count++;
                  $display("%0t: expected kind %0d data %02h last %0d, got kind %0d data %02h last %0d",
                           $time, want.kind, want.ch, want.last,
                           rsp_ch.kind, rsp_ch.data_out, rsp_ch.last);
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            rsp_stall = pick_gap(rsp_calm);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[serial_rx_ring_line_discipline] ERROR");
         $finish;
      end
   end

   initial begin : run_phases
      cfg_type c;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_BLOCKING;
      csr_wdata      = 1'b0;
      req_ch.valid   = 1'b0;
      req_ch.op      = OP_RX;
      req_ch.data_in = 8'h00;
      rsp_ch.ready   = 1'b0;
      foreach (ring_copy[i]) ring_copy[i] = 8'h00;
      wr_slot   = SLOT_W'(1);
      rd_slot   = SLOT_W'(1);
      read_held = 1'b0;
      model_cfg = '{blocking: 1'b1, echo: 1'b1, crlf: 1'b0, line_mode: 1'b0, semi_eol: 1'b0};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings written back explicitly; the spare indexes must do nothing.
      program_cfg('{blocking: 1'b1, echo: 1'b1, crlf: 1'b0, line_mode: 1'b0, semi_eol: 1'b0});
      write_reg(CSR_SPARE_LO, 1'b0);
      write_reg(CSR_SPARE_MID, 1'b0);
      write_reg(CSR_SPARE_HI, 1'b0);
      finish_writes();
      queue_req(OP_READ, 8'h00);
      queue_req(OP_READ, 8'hFF);
      queue_req(OP_RX, 8'h00);
      queue_req(OP_RX, 8'hFF);
      queue_req(OP_READ, 8'h00);
      queue_req(OP_WRITE, CH_LF);
      queue_req(OP_WRITE, 8'hFF);
      queue_req(OP_WRITE, 8'h00);
      queue_req(OP_UNUSED, 8'h55);
      queue_req(OP_RX, CH_CR);
      queue_req(OP_READ, 8'h00);
      settle();

      program_cfg('{blocking: 1'b1, echo: 1'b1, crlf: 1'b1, line_mode: 1'b1, semi_eol: 1'b1});
      queue_req(OP_RX, CH_CR);
      queue_req(OP_RX, CH_SEMI);
      queue_req(OP_RX, CH_LF);
      queue_req(OP_RX, 8'h61);
      repeat (4) queue_req(OP_READ, 8'h00);
      queue_req(OP_WRITE, CH_LF);
      queue_req(OP_WRITE, CH_CR);
      settle();

      // A read held over a change to nonblocking is still served by the next byte.
      queue_req(OP_READ, 8'h00);
      settle();
      write_reg(CSR_BLOCKING, 1'b0);
      write_reg(CSR_ECHO, 1'b0);
      finish_writes();
      queue_req(OP_RX, 8'h42);
      queue_req(OP_READ, 8'h00);
      settle();

      for (int p = 0; p < 6; p++) begin
         if (p == 0) begin
            c = '0;
         end else if (p == 1) begin
            c = '1;
         end else begin
            c = cfg_type'(5'($urandom_range(0, 31)));
         end
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         program_cfg(c);
         repeat (4) pending_reqs.push_back(pick_req());
         settle();
      end

      // Fill the ring past full so one byte is dropped, then drain it and read twice more.
      c = cfg_type'(5'($urandom_range(0, 31)));
      req_calm = 1'b0;
      rsp_calm = 1'b0;
      program_cfg(c);
      repeat (RING_SLOTS - 1) queue_req(OP_RX, pick_char());
      repeat (RING_SLOTS) queue_req(OP_READ, pick_char());
      settle();

      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("[serial_rx_ring_line_discipline] OK");
      end else begin
         $display("[serial_rx_ring_line_discipline] ERROR");
      end
      $finish;
   end

endmodule
